// ===== src/stereo_pan_lowpass_itd_delay_top_defines.svh =====
// ----------------------------------------------------------------------------
// stereo_pan_lowpass_itd_delay_top_defines
// Assertion macros for the stereo panner.
// ----------------------------------------------------------------------------
`ifndef STEREO_PAN_LOWPASS_ITD_DELAY_TOP_DEFINES_SVH
`define STEREO_PAN_LOWPASS_ITD_DELAY_TOP_DEFINES_SVH

// same-cycle implication
`define SPLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spld_pkg.sv =====
// ----------------------------------------------------------------------------
// spld_pkg
// Widths, reset values and register indexes of the stereo panner.
// ----------------------------------------------------------------------------
package spld_pkg;

    localparam int DELAY_DEPTH_DEF = 32;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 15;
    localparam int DLY_W     = 5;
    localparam int FILT_W    = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;

    localparam logic [GAIN_W-1:0] LEFT_GAIN_RST  = 15'd23170;
    localparam logic [GAIN_W-1:0] RIGHT_GAIN_RST = 15'd23170;
    localparam logic [GAIN_W-1:0] COEFF_RST      = 15'd29490;
    localparam logic [DLY_W-1:0]  DELAY_RST      = 5'd0;

    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_GAIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_DELAY  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_DELAY = 3'd4;

endpackage

// ===== src/stereo_pan_lowpass_itd_delay_top.sv =====
// A shared 25x16 multiplier runs the six products (gain, low-pass, output scale
// for each channel) one per cycle; a new sample is taken only once the last one
// has left the final step and the block is idle again.
// A result held on m_axis stalls the next sample in its last step until taken.
// Reset: registers to their defaults, filter states and ring position to zero;
// unwritten ring entries read as zero through a fill count, no clearing pass.
// ----------------------------------------------------------------------------
// stereo_pan_lowpass_itd_delay_top
// Mono to stereo panner with gain, one-pole low-pass and per-channel delay ring.
// ----------------------------------------------------------------------------
`include "stereo_pan_lowpass_itd_delay_top_defines.svh"

module stereo_pan_lowpass_itd_delay_top #(
    parameter int DELAY_DEPTH = spld_pkg::DELAY_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [15:0] in_sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // [15:0] left_out, [31:16] right_out
    input  logic                               cfg_we,
    input  logic [spld_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [spld_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import spld_pkg::*;

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;
    localparam logic [AW-1:0] LAST_POS  = AW'(DELAY_DEPTH - 1);
    localparam logic [CW-1:0] MAX_DLY   = CW'(DELAY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DELAY_DEPTH);
    localparam logic [AW:0]   DEPTH_F   = (AW+1)'(DELAY_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_COEF_L,
        ST_COEF_R,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_DONE
    } state_t;

    // configuration
    logic [GAIN_W-1:0] left_gain_reg, right_gain_reg, coeff_reg;
    logic [DLY_W-1:0]  left_delay_reg, right_delay_reg;

    // control
    state_t            state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW:0]       fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;
    logic              done_ok;

    // datapath
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [FILT_W-1:0]   fl_reg, fr_reg;
    logic signed [FILT_W:0]     d_reg;
    logic signed [40:0]         prod_reg;
    logic signed [FILT_W:0]     mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [FILT_W:0]     v_ext;
    logic signed [FILT_W-1:0]   f_sel;
    logic signed [FILT_W-1:0]   f_upd;
    logic signed [40:0]         round_q;
    logic [SAMPLE_W-1:0]        scaled;
    logic [SAMPLE_W-1:0]        lo_reg;
    logic [31:0]                out_data_reg;

    // ring addressing
    logic [CW-1:0]     wp_ext, dly_l_sat, dly_r_sat, idx_l_w, idx_r_w;
    logic [AW-1:0]     idx_l, idx_r;
    logic              dz_l_reg, dz_r_reg, vl_reg, vr_reg;
    logic [SAMPLE_W-1:0] left_ram  [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] right_ram [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] rdl_reg, rdr_reg;
    logic [SAMPLE_W-1:0] left_res, right_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign done_ok       = !out_valid_reg || m_axis_tready;

    // read index: saturate delay, step back from the write position
    assign wp_ext    = CW'(wp_reg);
    assign dly_l_sat = (CW'(left_delay_reg) > MAX_DLY) ? MAX_DLY : CW'(left_delay_reg);
    assign dly_r_sat = (CW'(right_delay_reg) > MAX_DLY) ? MAX_DLY : CW'(right_delay_reg);
    assign idx_l_w   = (wp_ext >= dly_l_sat) ? (wp_ext - dly_l_sat)
                                             : (wp_ext + DEPTH_C - dly_l_sat);
    assign idx_r_w   = (wp_ext >= dly_r_sat) ? (wp_ext - dly_r_sat)
                                             : (wp_ext + DEPTH_C - dly_r_sat);
    assign idx_l     = idx_l_w[AW-1:0];
    assign idx_r     = idx_r_w[AW-1:0];

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_GAIN_L:
            begin
                mul_a = (FILT_W+1)'(sample_reg);
                mul_b = $signed({1'b0, left_gain_reg});
            end
            ST_GAIN_R:
            begin
                mul_a = (FILT_W+1)'(sample_reg);
                mul_b = $signed({1'b0, right_gain_reg});
            end
            ST_COEF_L, ST_COEF_R:
            begin
                mul_a = d_reg;
                mul_b = $signed({1'b0, coeff_reg});
            end
            ST_SCALE_L:
            begin
                mul_a = {fl_reg[FILT_W-1], fl_reg};
                mul_b = $signed(FULL_SCALE);
            end
            ST_SCALE_R:
            begin
                mul_a = {fr_reg[FILT_W-1], fr_reg};
                mul_b = $signed(FULL_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign v_ext   = {prod_reg[30], prod_reg[30:7]};
    assign f_sel   = (state_reg == ST_GAIN_R) ? fl_reg : fr_reg;
    assign f_upd   = (state_reg == ST_COEF_R) ? fl_reg : fr_reg;
    assign round_q = prod_reg + (prod_reg[40] ? 41'sd8388607 : 41'sd0);
    assign scaled  = round_q[38:23];

    assign left_res  = dz_l_reg ? lo_reg : (vl_reg ? rdl_reg : '0);
    assign right_res = dz_r_reg ? scaled : (vr_reg ? rdr_reg : '0);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:    if (s_axis_tvalid) state_next = ST_GAIN_L;
            ST_GAIN_L:  state_next = ST_GAIN_R;
            ST_GAIN_R:  state_next = ST_COEF_L;
            ST_COEF_L:  state_next = ST_COEF_R;
            ST_COEF_R:  state_next = ST_SCALE_L;
            ST_SCALE_L: state_next = ST_SCALE_R;
            ST_SCALE_R: state_next = ST_DONE;
            ST_DONE:
            begin
                if (done_ok)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    wp_next        = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
                    fill_next      = (fill_reg == DEPTH_F) ? fill_reg : fill_reg + 1'b1;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and filter states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wp_reg          <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
            left_gain_reg   <= LEFT_GAIN_RST;
            right_gain_reg  <= RIGHT_GAIN_RST;
            coeff_reg       <= COEFF_RST;
            left_delay_reg  <= DELAY_RST;
            right_delay_reg <= DELAY_RST;
            fl_reg          <= '0;
            fr_reg          <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_LEFT_GAIN:   left_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                    REG_RIGHT_GAIN:  right_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_LOWPASS:     coeff_reg       <= cfg_wdata[GAIN_W-1:0];
                    REG_LEFT_DELAY:  left_delay_reg  <= cfg_wdata[DLY_W-1:0];
                    REG_RIGHT_DELAY: right_delay_reg <= cfg_wdata[DLY_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_COEF_R)
            begin
                fl_reg <= f_upd + prod_reg[38:15];
            end
            if (state_reg == ST_SCALE_L)
            begin
                fr_reg <= f_upd + prod_reg[38:15];
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        // hold the right product while the result waits
        if (state_reg != ST_DONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= $signed(s_axis_tdata);
        end
        if (state_reg == ST_GAIN_R || state_reg == ST_COEF_L)
        begin
            d_reg <= v_ext - {f_sel[FILT_W-1], f_sel};
        end
        if (state_reg == ST_GAIN_L)
        begin
            dz_l_reg <= (dly_l_sat == '0);
            dz_r_reg <= (dly_r_sat == '0);
            vl_reg   <= ({1'b0, idx_l} < fill_reg);
            vr_reg   <= ({1'b0, idx_r} < fill_reg);
        end
        if (state_reg == ST_SCALE_R)
        begin
            lo_reg <= scaled;
        end
        if (state_reg == ST_DONE && done_ok)
        begin
            out_data_reg <= {right_res, left_res};
        end
    end

    // left ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCALE_R)
        begin
            left_ram[wp_reg] <= scaled;
        end
        if (state_reg == ST_GAIN_L)
        begin
            rdl_reg <= left_ram[idx_l];
        end
    end

    // right ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            right_ram[wp_reg] <= scaled;
        end
        if (state_reg == ST_GAIN_L)
        begin
            rdr_reg <= right_ram[idx_r];
        end
    end

    `SPLD_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= DEPTH_F, "fill count past depth")
    `SPLD_ASSERT_NOW(a_wp_bound, clk, rst_n, 1'b1, wp_reg <= LAST_POS, "write position out of ring")
    `SPLD_ASSERT_NOW(a_no_min, clk, rst_n, m_axis_tvalid, (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000), "output beyond full scale")
    `SPLD_ASSERT_NEXT(a_load, clk, rst_n, (state_reg == ST_DONE) && done_ok, m_axis_tvalid && (wp_reg == (($past(wp_reg) == LAST_POS) ? '0 : $past(wp_reg) + 1'b1)), "result not loaded with ring advance")

endmodule

// ===== verif/stereo_pan_lowpass_itd_delay_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_pan_lowpass_itd_delay_top_test
// Self-checking bench for the mono to stereo panner.
// A tracker class computes, per accepted mono sample, the expected stereo pair
// from its own copy of the gain, low-pass and delay settings, the filter states
// and the delay rings. Every pair leaving the block is compared with the oldest
// expected pair. Directed samples cover the extremes and the odd register
// writes, then random phases run with new settings and random stalls on both
// sides.
// ----------------------------------------------------------------------------
module stereo_pan_lowpass_itd_delay_top_test;

    import spld_pkg::*;

    localparam int     LATENCY     = 8;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     RANDOM_ITEMS = 1500;
    localparam longint Q23_ONE     = 64'sd8388608;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_pair_t;

    class pan_pair_tracker;
        logic [GAIN_W-1:0]          left_gain;
        logic [GAIN_W-1:0]          right_gain;
        logic [GAIN_W-1:0]          alpha;
        logic [DLY_W-1:0]           left_delay;
        logic [DLY_W-1:0]           right_delay;
        int                         left_state;
        int                         right_state;
        logic signed [SAMPLE_W-1:0] left_ring [DELAY_DEPTH_DEF];
        logic signed [SAMPLE_W-1:0] right_ring [DELAY_DEPTH_DEF];
        int unsigned                wr_pos;
        stereo_pair_t               pending_pairs [$];
        int                         failures;

        function new();
            left_gain   = LEFT_GAIN_RST;
            right_gain  = RIGHT_GAIN_RST;
            alpha       = COEFF_RST;
            left_delay  = DELAY_RST;
            right_delay = DELAY_RST;
            left_state  = 0;
            right_state = 0;
            wr_pos      = 0;
            failures    = 0;
            foreach (left_ring[i])
            begin
                left_ring[i]  = '0;
                right_ring[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LEFT_GAIN:   left_gain   = value[GAIN_W-1:0];
                REG_RIGHT_GAIN:  right_gain  = value[GAIN_W-1:0];
                REG_LOWPASS:     alpha       = value[GAIN_W-1:0];
                REG_LEFT_DELAY:  left_delay  = value[DLY_W-1:0];
                REG_RIGHT_DELAY: right_delay = value[DLY_W-1:0];
                default: ;
            endcase
        endfunction

        function int lowpass_step(int state, logic signed [SAMPLE_W-1:0] s,
                                  logic [GAIN_W-1:0] gain);
            longint scaled;
            longint diff;
            scaled = (longint'(s) * longint'(gain)) >>> 7;
            diff   = scaled - longint'(state);
            return int'(longint'(state) + ((diff * longint'(alpha)) >>> 15));
        endfunction

        function logic signed [SAMPLE_W-1:0] to_pcm(int f);
            longint c;
            c = f;
            if (c > Q23_ONE)
                c = Q23_ONE;
            if (c < -Q23_ONE)
                c = -Q23_ONE;
            return SAMPLE_W'((c * longint'(FULL_SCALE)) / Q23_ONE);
        endfunction

        function void accept_sample(logic [SAMPLE_W-1:0] raw);
            stereo_pair_t pair;
            left_state  = lowpass_step(left_state, raw, left_gain);
            right_state = lowpass_step(right_state, raw, right_gain);
            left_ring[wr_pos]  = to_pcm(left_state);
            right_ring[wr_pos] = to_pcm(right_state);
            pair.left  = left_ring[(wr_pos + DELAY_DEPTH_DEF - left_delay) % DELAY_DEPTH_DEF];
            pair.right = right_ring[(wr_pos + DELAY_DEPTH_DEF - right_delay) % DELAY_DEPTH_DEF];
            wr_pos = (wr_pos + 1) % DELAY_DEPTH_DEF;
            pending_pairs.push_back(pair);
        endfunction

        function void report(string what, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
            failures++;
            if (failures <= 100)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, $signed(want), $signed(got));
        endfunction

        function void check_pair(logic [2*SAMPLE_W-1:0] tdata);
            stereo_pair_t want;
            if (pending_pairs.size() == 0)
            begin
                failures++;
                if (failures <= 100)
                    $display("%0t: unexpected pair, expected none, actual %h", $time, tdata);
                return;
            end
            want = pending_pairs.pop_front();
            if (tdata[SAMPLE_W-1:0] !== want.left)
                report("left_out", want.left, tdata[SAMPLE_W-1:0]);
            if (tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right)
                report("right_out", want.right, tdata[2*SAMPLE_W-1:SAMPLE_W]);
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_W-1:0]     s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [2*SAMPLE_W-1:0]   m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    pan_pair_tracker tracker = new();
    bit              smooth_run = 1'b0;

    stereo_pan_lowpass_itd_delay_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (smooth_run || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 20);
        return $urandom_range(30, 100);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 15'h7FFF;
            2:       return 15'd1;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay_word();
        logic [DLY_W-1:0] d;
        case ($urandom_range(0, 3))
            0:       d = '0;
            1:       d = '1;
            default: d = DLY_W'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0)
            return {10'($urandom), d};
        return {10'd0, d};
    endfunction

    // hold valid over back-to-back transfers; lower it only ahead of a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.accept_sample(s);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic random_settings();
        drain();
        if ($urandom_range(0, 4) != 0)
            write_reg(REG_LEFT_GAIN, pick_coeff());
        if ($urandom_range(0, 4) != 0)
            write_reg(REG_RIGHT_GAIN, pick_coeff());
        if ($urandom_range(0, 4) != 0)
            write_reg(REG_LOWPASS, pick_coeff());
        if ($urandom_range(0, 4) != 0)
            write_reg(REG_LEFT_DELAY, pick_delay_word());
        if ($urandom_range(0, 4) != 0)
            write_reg(REG_RIGHT_DELAY, pick_delay_word());
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_RIGHT_DELAY + 3'($urandom_range(1, 3)), 15'($urandom));
        smooth_run = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("stereo_pan_lowpass_itd_delay_top test failed");
        $finish;
    end

    initial
    begin
        int hold;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_pair(m_axis_tdata);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!smooth_run && $urandom_range(0, 99) < 15)
                    hold = gap_length();
            end
        end
    end

    initial
    begin
        int             n;
        int             sent;
        int             run_left;
        logic [SAMPLE_W-1:0] held;

        sent     = 0;
        run_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults after reset
        send_sample(16'h7FFF, gap_length());
        send_sample(16'h8000, gap_length());
        send_sample(16'h0000, gap_length());
        send_sample(16'h0001, gap_length());
        send_sample(16'hFFFF, gap_length());
        send_sample(16'h5555, gap_length());
        send_sample(16'hAAAA, gap_length());

        // full gain and alpha, left delay from a wide word, right delay at the ring end
        drain();
        write_reg(REG_LEFT_GAIN, 15'h7FFF);
        write_reg(REG_RIGHT_GAIN, 15'h7FFF);
        write_reg(REG_LOWPASS, 15'h7FFF);
        write_reg(REG_LEFT_DELAY, 15'h0041);
        write_reg(REG_RIGHT_DELAY, 15'h7FFF);
        write_reg(REG_RIGHT_DELAY + 3'd1, 15'h0000);
        write_reg(REG_RIGHT_DELAY + 3'd2, 15'h1234);
        write_reg(REG_RIGHT_DELAY + 3'd3, 15'h7FFF);
        repeat (6) send_sample(16'h8000, gap_length());
        repeat (4) send_sample(16'h7FFF, gap_length());

        // zero gain and frozen filter
        drain();
        write_reg(REG_LEFT_GAIN, 15'h0000);
        write_reg(REG_RIGHT_GAIN, 15'h0000);
        write_reg(REG_LOWPASS, 15'h0000);
        write_reg(REG_LEFT_DELAY, 15'h0000);
        send_sample(16'h7FFF, gap_length());
        send_sample(16'h8000, gap_length());

        while (sent < RANDOM_ITEMS)
        begin
            random_settings();
            n = $urandom_range(40, 200);
            for (int i = 0; i < n; i++)
            begin
                if (run_left == 0)
                begin
                    held     = pick_sample();
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : 1;
                end
                run_left--;
                send_sample(held, gap_length());
                sent++;
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (LATENCY * 2) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("stereo_pan_lowpass_itd_delay_top test passed");
        else
            $display("stereo_pan_lowpass_itd_delay_top test failed");
        $finish;
    end

endmodule
